>>> hw/rtl/assert_macros.svh
// Assertion macros included by the core RTL of the bucket assigner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, disabled while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/llba_pkg.sv
// Shared widths, register indexes and defaults of the least-loaded bucket assigner.
package llba_pkg;

  localparam int DEFAULT_MAX_SLICES = 16;

  localparam int WEIGHT_W    = 20;
  localparam int LOAD_W      = 40;
  localparam int ROOM_W      = 25;
  localparam int SLICE_IDX_W = 4;

  localparam int ACT_W   = 5;
  localparam int BASE_W  = 24;
  localparam int EXTRA_W = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_SLICES = 2'd0,
    CFG_BASE_CAPACITY = 2'd1,
    CFG_EXTRA_SLICES  = 2'd2
  } cfg_reg_t;

endpackage

>>> hw/rtl/least_loaded_bucket_assigner_core.sv
// Least-loaded bucket assigner: places weighted rows on the lightest slice with room.
//
// Each request carries one row weight. The row goes to the active slice with the
// smallest accumulated weight among the slices that still have room; ties go to
// the lowest slice index. That slice loses one unit of room and gains the weight,
// saturating at 2^40 - 1, and the result reports the slice and its new total.
// When no active slice has room the result has no_room set, index and total are
// zero, and nothing changes. The block takes one request every clock cycle while
// the result channel is not stalled. An accepted request is held in the input
// register until the result register is empty or being read; then a single pass
// through a comparator tree over all MAX_SLICES loads and a saturating adder
// fills the result register, and its update is visible to the very next request.
// That tree and adder form the critical path. Any write to a listed
// configuration register clears every load and reloads every room from the new
// settings in the same cycle; there is no clearing pass. Writes are expected
// only while no request is in flight.
module least_loaded_bucket_assigner_core #(
  parameter int MAX_SLICES = llba_pkg::DEFAULT_MAX_SLICES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration write port.
  input  logic                             cfg_we,
  input  logic [llba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [llba_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // Request channel.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [19:0] row_weight, [23:20] zero
  input  logic [llba_pkg::IN_TDATA_W-1:0]  in_tdata,
  // Result channel.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [3:0] slice_index, [43:4] slice_total, [47:44] zero
  output logic [llba_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] no_room
  output logic [llba_pkg::OUT_TUSER_W-1:0] out_tuser
);

  `include "assert_macros.svh"

  localparam int IDX_W  = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
  localparam int LEAVES = 1 << IDX_W;

  // One contender in the minimum search.
  typedef struct packed {
    logic                        vld;
    logic [llba_pkg::LOAD_W-1:0] load;
    logic [IDX_W-1:0]            idx;
  } cand_t;

  // Configuration registers.
  logic [llba_pkg::ACT_W-1:0]   active_slices_r, active_slices_nxt;
  logic [llba_pkg::BASE_W-1:0]  base_capacity_r, base_capacity_nxt;
  logic [llba_pkg::EXTRA_W-1:0] extra_slices_r,  extra_slices_nxt;
  logic                         cfg_hit_c;

  // Per-slice state.
  logic [llba_pkg::LOAD_W-1:0] slice_load_r [MAX_SLICES];
  logic [llba_pkg::LOAD_W-1:0] slice_load_nxt [MAX_SLICES];
  logic [llba_pkg::ROOM_W-1:0] slice_room_r [MAX_SLICES];
  logic [llba_pkg::ROOM_W-1:0] slice_room_nxt [MAX_SLICES];
  logic                        loads_clear_c;

  // Input stage.
  logic                          s1_valid_r, s1_valid_nxt;
  logic [llba_pkg::WEIGHT_W-1:0] s1_weight_r;
  logic                          in_accept_c;
  logic                          s2_load_c;

  // Selection and update.
  cand_t                         node_c [2*LEAVES];
  logic                          no_room_c;
  logic [llba_pkg::LOAD_W:0]     sum_c;
  logic [llba_pkg::LOAD_W-1:0]   total_c;

  // Result register.
  logic                             out_valid_r, out_valid_nxt;
  logic [llba_pkg::SLICE_IDX_W-1:0] out_idx_r;
  logic [llba_pkg::LOAD_W-1:0]      out_total_r;
  logic                             out_no_room_r;

  // Handshake: the input register drains into the result register whenever the
  // result register is empty or being read, so a stalled result still lets the
  // input register fill once.
  assign s2_load_c   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready   = !s1_valid_r || s2_load_c;
  assign in_accept_c = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept_c) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_load_c) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s2_load_c) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Configuration decode. A write beyond the register list changes nothing.
  always_comb begin
    active_slices_nxt = active_slices_r;
    base_capacity_nxt = base_capacity_r;
    extra_slices_nxt  = extra_slices_r;
    cfg_hit_c         = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        llba_pkg::CFG_ACTIVE_SLICES: begin
          active_slices_nxt = cfg_wdata[llba_pkg::ACT_W-1:0];
          cfg_hit_c         = 1'b1;
        end
        llba_pkg::CFG_BASE_CAPACITY: begin
          base_capacity_nxt = cfg_wdata[llba_pkg::BASE_W-1:0];
          cfg_hit_c         = 1'b1;
        end
        llba_pkg::CFG_EXTRA_SLICES: begin
          extra_slices_nxt = cfg_wdata[llba_pkg::EXTRA_W-1:0];
          cfg_hit_c        = 1'b1;
        end
        default: begin
          cfg_hit_c = 1'b0;
        end
      endcase
    end
  end

  // Minimum search as a binary tree: leaves sit at LEAVES + i, node k merges
  // children 2k and 2k+1. The left child holds the lower indexes, so it wins
  // ties. A slice counts when it is active and has room; slice 0 is always
  // active, which also covers an active_slices of zero.
  always_comb begin
    for (int i = 0; i < LEAVES; i++) begin
      node_c[LEAVES+i].idx = IDX_W'(i);
      if (i < MAX_SLICES) begin
        node_c[LEAVES+i].vld  = ((i == 0) || (32'(i) < 32'(active_slices_r))) &&
                                (slice_room_r[i] != '0);
        node_c[LEAVES+i].load = slice_load_r[i];
      end else begin
        node_c[LEAVES+i].vld  = 1'b0;
        node_c[LEAVES+i].load = '0;
      end
    end
    node_c[0] = '0;
    for (int k = LEAVES - 1; k >= 1; k--) begin
      if (node_c[2*k].vld &&
          (!node_c[2*k+1].vld || (node_c[2*k].load <= node_c[2*k+1].load))) begin
        node_c[k] = node_c[2*k];
      end else begin
        node_c[k] = node_c[2*k+1];
      end
    end
  end

  assign no_room_c = !node_c[1].vld;
  assign sum_c     = {1'b0, node_c[1].load} +
                     (llba_pkg::LOAD_W + 1)'(s1_weight_r);
  assign total_c   = sum_c[llba_pkg::LOAD_W] ? '1 : sum_c[llba_pkg::LOAD_W-1:0];

  // State update. A configuration write takes priority and reloads every slice.
  always_comb begin
    loads_clear_c = 1'b1;
    for (int i = 0; i < MAX_SLICES; i++) begin
      slice_load_nxt[i] = slice_load_r[i];
      slice_room_nxt[i] = slice_room_r[i];
      if (slice_load_r[i] != '0) begin
        loads_clear_c = 1'b0;
      end
      if (cfg_hit_c) begin
        slice_load_nxt[i] = '0;
        slice_room_nxt[i] = llba_pkg::ROOM_W'(base_capacity_nxt) +
                            llba_pkg::ROOM_W'(32'(i) < 32'(extra_slices_nxt));
      end else if (s2_load_c && !no_room_c && (node_c[1].idx == IDX_W'(i))) begin
        slice_load_nxt[i] = total_c;
        slice_room_nxt[i] = slice_room_r[i] - llba_pkg::ROOM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_slices_r <= llba_pkg::ACT_W'(1);
      base_capacity_r <= '0;
      extra_slices_r  <= '0;
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      for (int i = 0; i < MAX_SLICES; i++) begin
        slice_load_r[i] <= '0;
        slice_room_r[i] <= '0;
      end
    end else begin
      active_slices_r <= active_slices_nxt;
      base_capacity_r <= base_capacity_nxt;
      extra_slices_r  <= extra_slices_nxt;
      s1_valid_r      <= s1_valid_nxt;
      out_valid_r     <= out_valid_nxt;
      for (int i = 0; i < MAX_SLICES; i++) begin
        slice_load_r[i] <= slice_load_nxt[i];
        slice_room_r[i] <= slice_room_nxt[i];
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_accept_c) begin
      s1_weight_r <= in_tdata[llba_pkg::WEIGHT_W-1:0];
    end
    if (s2_load_c) begin
      out_no_room_r <= no_room_c;
      out_idx_r     <= no_room_c ? '0 : llba_pkg::SLICE_IDX_W'(node_c[1].idx);
      out_total_r   <= no_room_c ? '0 : total_c;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(llba_pkg::OUT_TDATA_W - llba_pkg::LOAD_W - llba_pkg::SLICE_IDX_W)'(0),
                       out_total_r, out_idx_r};
  assign out_tuser  = out_no_room_r;

  // A refused row reports zero index and zero total.
  `ASSERT_CLK(a_no_room_zero, (out_valid_r && out_no_room_r) |-> ((out_idx_r == '0) && (out_total_r == '0)), "no_room result carries nonzero fields")
  // A listed configuration write leaves every load cleared.
  `ASSERT_CLK(a_cfg_clears, cfg_hit_c |=> loads_clear_c, "loads not cleared after configuration write")
  // A held request keeps its weight while the result side is stalled.
  `ASSERT_CLK(a_s1_hold, (s1_valid_r && !s2_load_c) |=> (s1_valid_r && $stable(s1_weight_r)), "input stage lost or changed a stalled request")
  // A placed row reports a total no smaller than its own weight.
  `ASSERT_CLK(a_total_ge_weight, (s2_load_c && !no_room_c) |=> (out_total_r >= $past(s1_weight_r)), "slice total below row weight")

endmodule
